@@ src/suit_pkg.sv @@
package suit_pkg;

  // Command codes
  localparam logic [1:0] CMD_INSERT    = 2'd0;
  localparam logic [1:0] CMD_DUMP_ASC  = 2'd1;
  localparam logic [1:0] CMD_DUMP_DESC = 2'd2;
  localparam logic [1:0] CMD_CLEAR     = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_INSERTED   = 3'd0;
  localparam logic [2:0] ST_DUPLICATE  = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_DUMP_ENTRY = 3'd3;
  localparam logic [2:0] ST_DUMP_EMPTY = 3'd4;
  localparam logic [2:0] ST_CLEARED    = 3'd5;

  // Cell operating modes
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_ROTATE = 2'd2;

  localparam int ValueWidth = 32;
  localparam int CountWidth = 6;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [ValueWidth-1:0] value;
  } request_t;

  typedef struct packed {
    logic [2:0]                   status;
    logic signed [ValueWidth-1:0] entry;
    logic [CountWidth-1:0]        entry_count;
    logic                         last_of_run;
  } result_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [ValueWidth-1:0] ins_value;
  } cell_ctl_t;

endpackage

@@ src/suit_cell.sv @@
module suit_cell
  import suit_pkg::*;
(
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic                         occ,        // this slot holds a live entry
  input  logic                         prev_less,  // left neighbor below value (1 at head)
  input  logic signed [ValueWidth-1:0] shift_in,   // left neighbor entry
  input  logic signed [ValueWidth-1:0] rot_in,     // rotate source
  output logic signed [ValueWidth-1:0] val,
  output logic                         less,
  output logic                         eq
);

  // Compare against the broadcast value
  assign less = occ && (val < ctl.ins_value);
  assign eq   = occ && (val == ctl.ins_value);

  // Insert: slot at the sorted position takes the value, slots above shift up; rotate loads rot_in
  always_ff @(posedge clk) begin
    case (ctl.mode)
      MODE_INSERT: begin
        if (!less) begin
          val <= prev_less ? ctl.ins_value : shift_in;
        end
      end
      MODE_ROTATE: begin
        val <= rot_in;
      end
      default: begin
        val <= val;
      end
    endcase
  end

endmodule

@@ src/sorted_unique_insert_table_unit.sv @@
// Insert and clear results are registered and show in the cycle after the transfer;
// a dump passes the dumping flag, then the result register, and shows its entries in
// consecutive cycles. Throughput: one insert or clear per cycle while not busy; a
// dump holds busy while the chain rotates one entry per cycle, restoring the table.
// Reset (rst, synchronous) empties the table. Results cannot be stalled.
module sorted_unique_insert_table_unit
  import suit_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     result_valid,
  output result_t  result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [CW-1:0] count;
  logic [CW-1:0] remaining;
  logic          dumping;
  logic          dump_desc;

  logic signed [ValueWidth-1:0] val [CAPACITY];
  logic signed [ValueWidth-1:0] rot_in [CAPACITY];
  logic [CAPACITY-1:0]          less;
  logic [CAPACITY-1:0]          eq;

  logic          accept;
  logic          dup;
  logic          full;
  logic          ins_ok;
  logic [IW-1:0] tail_idx;
  logic signed [ValueWidth-1:0] tail_val;
  cell_ctl_t     ctl;

  assign busy   = dumping;
  assign accept = start && !busy;
  assign dup    = |eq;
  assign full   = (count == CW'(CAPACITY));
  assign ins_ok = accept && (request.command == CMD_INSERT) && !dup && !full;

  assign tail_idx = IW'(count - 1'b1);
  assign tail_val = val[tail_idx];

  // Broadcast control to the chain
  always_comb begin
    ctl.ins_value = request.value;
    if (ins_ok) begin
      ctl.mode = MODE_INSERT;
    end else if (dumping) begin
      ctl.mode = MODE_ROTATE;
    end else begin
      ctl.mode = MODE_HOLD;
    end
  end

  // Cell chain
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic                         prev_less;
      logic signed [ValueWidth-1:0] shift_in;
      logic                         occ;

      assign occ = (CW'(g) < count);

      if (g == 0) begin : g_head
        assign prev_less = 1'b1;
        assign shift_in  = request.value;
        // a single live entry rotates onto itself
        assign rot_in[g] = dump_desc ? tail_val :
                           ((count == CW'(1)) ? val[0] : val[1]);
      end else if (g == CAPACITY - 1) begin : g_end
        assign prev_less = less[g-1];
        assign shift_in  = val[g-1];
        assign rot_in[g] = dump_desc ? val[g-1] : val[0];
      end else begin : g_mid
        assign prev_less = less[g-1];
        assign shift_in  = val[g-1];
        // ascending rotation wraps the head entry into the last live slot
        assign rot_in[g] = dump_desc ? val[g-1] :
                           ((CW'(g) == count - 1'b1) ? val[0] : val[g+1]);
      end

      suit_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ),
        .prev_less (prev_less),
        .shift_in  (shift_in),
        .rot_in    (rot_in[g]),
        .val       (val[g]),
        .less      (less[g]),
        .eq        (eq[g])
      );
    end
  endgenerate

  // Command sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      dumping      <= 1'b0;
      dump_desc    <= 1'b0;
      remaining    <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (accept) begin
        case (request.command)
          CMD_INSERT: begin
            result_valid       <= 1'b1;
            result.entry       <= '0;
            result.last_of_run <= 1'b1;
            if (dup) begin
              result.status      <= ST_DUPLICATE;
              result.entry_count <= CountWidth'(count);
            end else if (full) begin
              result.status      <= ST_FULL;
              result.entry_count <= CountWidth'(count);
            end else begin
              count              <= count + 1'b1;
              result.status      <= ST_INSERTED;
              result.entry_count <= CountWidth'(count + 1'b1);
            end
          end
          CMD_CLEAR: begin
            count              <= '0;
            result_valid       <= 1'b1;
            result.status      <= ST_CLEARED;
            result.entry       <= '0;
            result.entry_count <= '0;
            result.last_of_run <= 1'b1;
          end
          default: begin
            if (count == '0) begin
              result_valid       <= 1'b1;
              result.status      <= ST_DUMP_EMPTY;
              result.entry       <= '0;
              result.entry_count <= '0;
              result.last_of_run <= 1'b1;
            end else begin
              dumping   <= 1'b1;
              dump_desc <= (request.command == CMD_DUMP_DESC);
              remaining <= count;
            end
          end
        endcase
      end else if (dumping) begin
        // one entry per cycle while the chain rotates
        result_valid       <= 1'b1;
        result.status      <= ST_DUMP_ENTRY;
        result.entry       <= dump_desc ? tail_val : val[0];
        result.entry_count <= CountWidth'(count);
        result.last_of_run <= (remaining == CW'(1));
        remaining          <= remaining - 1'b1;
        if (remaining == CW'(1)) begin
          dumping <= 1'b0;
        end
      end
    end
  end

endmodule

@@ src/suit_checker.sv @@
module suit_checker
  import suit_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input request_t request,
  input logic     result_valid,
  input result_t  result
);

  // An insert transfer answers in the next cycle with a single result
  a_insert_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == CMD_INSERT |=> result_valid && result.last_of_run)
    else $error("insert produced no result");

  // A dump run continues without gaps until its last entry
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_of_run |=> result_valid && result.status == ST_DUMP_ENTRY)
    else $error("dump run broken");

  // Non-entry results carry a zero entry
  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_DUMP_ENTRY |-> result.entry == '0)
    else $error("nonzero entry on non-dump result");

  // The final result of a run releases the command port
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_of_run |-> !busy)
    else $error("busy on final result");

  // Clear leaves an empty table
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_CLEARED |-> result.entry_count == '0)
    else $error("clear reported entries");

endmodule

bind sorted_unique_insert_table_unit suit_checker u_suit_checker (.*);

@@ sim/testbench.sv @@
module testbench;
  import suit_pkg::*;

  localparam int TABLE_CAPACITY = 32;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 2 * TABLE_CAPACITY + 8;
  localparam logic signed [ValueWidth-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [ValueWidth-1:0] VALUE_MAX = 32'sh7fff_ffff;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     result_valid;
  result_t  result;

  // Shadow copy of the table, kept ascending, and the results still owed
  logic signed [ValueWidth-1:0] shadow_entries[$];
  result_t                      pending_results[$];

  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;

  sorted_unique_insert_table_unit #(
    .CAPACITY(TABLE_CAPACITY)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .result_valid(result_valid),
    .result      (result)
  );

  always #6 clk = ~clk;

  // Free-running cycle count, watched by the timeout below
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic void owe_result(input logic [2:0] status,
                                     input logic signed [ValueWidth-1:0] entry,
                                     input logic last);
    result_t r;
    r.status      = status;
    r.entry       = entry;
    r.entry_count = CountWidth'(shadow_entries.size());
    r.last_of_run = last;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow table and queue its results
  function automatic void apply_to_shadow_table(input request_t req);
    int pos;
    int n;
    int idx;
    pos = 0;
    n = shadow_entries.size();
    case (req.command)
      CMD_INSERT: begin
        while (pos < n && shadow_entries[pos] < req.value) pos++;
        if (pos < n && shadow_entries[pos] == req.value) begin
          owe_result(ST_DUPLICATE, '0, 1'b1);
        end else if (n >= TABLE_CAPACITY) begin
          owe_result(ST_FULL, '0, 1'b1);
        end else begin
          shadow_entries.insert(pos, req.value);
          owe_result(ST_INSERTED, '0, 1'b1);
        end
      end
      CMD_CLEAR: begin
        shadow_entries.delete();
        owe_result(ST_CLEARED, '0, 1'b1);
      end
      CMD_DUMP_ASC, CMD_DUMP_DESC: begin
        if (n == 0) begin
          owe_result(ST_DUMP_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            idx = (req.command == CMD_DUMP_ASC) ? i : n - 1 - i;
            owe_result(ST_DUMP_ENTRY, shadow_entries[idx], i == n - 1);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result checker: every strobe is matched against the oldest owed result
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d entry %0d",
                 $time, result.status, result.entry);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, result.status);
        check_field("entry", want.entry, result.entry);
        check_field("entry_count", want.entry_count, result.entry_count);
        check_field("last_of_run", want.last_of_run, result.last_of_run);
      end
    end
  end

  // One command transfer; start stays high so the next one can follow at once
  task automatic send_request(input logic [1:0] cmd,
                              input logic signed [ValueWidth-1:0] val);
    request_t req;
    req.command = cmd;
    req.value   = val;
    request <= req;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    apply_to_shadow_table(req);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Sender pacing: bursts of random length, random gaps between them
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_gap($urandom_range(1, 7));
      burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 12);
    end
  endtask

  task automatic send_paced(input logic [1:0] cmd, input logic signed [ValueWidth-1:0] val);
    send_request(cmd, val);
    pace();
  endtask

  // Mostly a small pool so duplicates are common, plus wide and extreme values
  function automatic logic signed [ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_value = int'($urandom_range(0, 40)) - 20;
      4, 5, 6:    pick_value = $urandom;
      7:          pick_value = VALUE_MIN + $urandom_range(0, 3);
      8:          pick_value = VALUE_MAX - $urandom_range(0, 3);
      default:    pick_value = -int'($urandom_range(0, 1));
    endcase
  endfunction

  // Dumps and clears on an empty table, then an insert into an empty table
  task automatic test_empty_table();
    send_paced(CMD_DUMP_ASC, $urandom);
    send_paced(CMD_DUMP_DESC, $urandom);
    send_paced(CMD_CLEAR, $urandom);
    send_paced(CMD_INSERT, 32'sd7);
    send_paced(CMD_DUMP_ASC, $urandom);
    send_paced(CMD_DUMP_DESC, $urandom);
    idle_gap(3);
  endtask

  // Extreme values, duplicates, both dump orders, clear then dump
  task automatic test_extremes();
    send_paced(CMD_INSERT, VALUE_MAX);
    send_paced(CMD_INSERT, VALUE_MIN);
    send_paced(CMD_INSERT, 32'sd0);
    send_paced(CMD_INSERT, -32'sd1);
    send_paced(CMD_INSERT, 32'sd1);
    send_paced(CMD_INSERT, VALUE_MIN);
    send_paced(CMD_INSERT, 32'sd0);
    send_paced(CMD_INSERT, VALUE_MAX);
    send_paced(CMD_DUMP_ASC, $urandom);
    send_paced(CMD_DUMP_DESC, $urandom);
    send_paced(CMD_CLEAR, $urandom);
    send_paced(CMD_DUMP_DESC, $urandom);
    send_paced(CMD_INSERT, VALUE_MIN);
    idle_gap(3);
  endtask

  // Fill to capacity, then stored values (duplicate wins over full) and a random one
  task automatic test_fill_rounds(input int rounds);
    for (int r = 0; r < rounds; r++) begin
      send_paced(CMD_CLEAR, $urandom);
      while (shadow_entries.size() < TABLE_CAPACITY) begin
        if ($urandom_range(0, 9) == 0) begin
          send_paced($urandom_range(0, 1) ? CMD_DUMP_ASC : CMD_DUMP_DESC, $urandom);
        end else begin
          send_paced(CMD_INSERT, pick_value());
        end
      end
      send_paced(CMD_INSERT, shadow_entries[$urandom_range(0, TABLE_CAPACITY - 1)]);
      send_paced(CMD_INSERT, pick_value());
      send_paced(CMD_INSERT, shadow_entries[0]);
      send_paced(CMD_INSERT, shadow_entries[TABLE_CAPACITY - 1]);
      send_paced(CMD_DUMP_ASC, $urandom);
      send_paced(CMD_DUMP_DESC, $urandom);
    end
    idle_gap(3);
  endtask

  // Random mix of all commands with values from the same distribution
  task automatic test_random_mix(input int items);
    int op;
    for (int k = 0; k < items; k++) begin
      op = $urandom_range(0, 99);
      if (op < 6) begin
        send_paced(CMD_CLEAR, $urandom);
      end else if (op < 14) begin
        send_paced(CMD_DUMP_ASC, $urandom);
      end else if (op < 22) begin
        send_paced(CMD_DUMP_DESC, $urandom);
      end else begin
        send_paced(CMD_INSERT, pick_value());
      end
    end
    idle_gap(3);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_fill_rounds(4);
    test_random_mix(300);

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sorted_unique_insert_table_unit.f @@
src/suit_pkg.sv
src/suit_cell.sv
src/sorted_unique_insert_table_unit.sv
src/suit_checker.sv
sim/testbench.sv
